@@ design/kde_pkg.sv @@
// ----------------------------------------------------------------------------
// kde_pkg: shared constants for the key debounce event detector
// Key count, field widths and the no-event code used by every file.
// ----------------------------------------------------------------------------
package kde_pkg;

  localparam int NUM_KEYS = 4;
  localparam int RAW_W    = 4;
  localparam int COUNT_W  = 8;
  localparam int EVENT_W  = 3;

  // keys with no bit in the raw sample read as released
  localparam int HELD_W = (NUM_KEYS < RAW_W) ? NUM_KEYS : RAW_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] MIN_PRESS_RESET = COUNT_W'(7);
  localparam logic [EVENT_W-1:0] KEY_NONE        = EVENT_W'(NUM_KEYS);

  typedef logic [RAW_W-1:0]   raw_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [EVENT_W-1:0] event_t;

endpackage

@@ design/kde_core.sv @@
// ----------------------------------------------------------------------------
// kde_core: per-key hold counters and reported flags
// Updates keys for one sample and picks the lowest key that fires; keys above it keep their state.
// ----------------------------------------------------------------------------
module kde_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [kde_pkg::RAW_W-1:0]           raw_keys_i,
  input  kde_pkg::count_t                     min_press_count_i,
  output kde_pkg::event_t                     key_event_o
);

  kde_pkg::count_t                 count_q [kde_pkg::NUM_KEYS];
  kde_pkg::count_t                 count_d [kde_pkg::NUM_KEYS];
  logic [kde_pkg::NUM_KEYS-1:0]    flag_q;
  logic [kde_pkg::NUM_KEYS-1:0]    flag_d;
  logic [kde_pkg::NUM_KEYS-1:0]    held;

  always_comb begin
    held = '0;
    held[kde_pkg::HELD_W-1:0] = raw_keys_i[kde_pkg::HELD_W-1:0];
  end

  always_comb begin
    kde_pkg::count_t inc;
    logic            done;
    done        = 1'b0;
    key_event_o = kde_pkg::KEY_NONE;
    flag_d      = flag_q;
    for (int k = 0; k < kde_pkg::NUM_KEYS; k++) begin
      count_d[k] = count_q[k];
      inc = (count_q[k] == kde_pkg::COUNT_MAX) ? count_q[k] :
            count_q[k] + kde_pkg::count_t'(1);
      // once a lower key fires, higher keys keep their state
      if (!done) begin
        if (held[k]) begin
          if (inc >= min_press_count_i && !flag_q[k]) begin
            flag_d[k]   = 1'b1;
            count_d[k]  = '0;
            key_event_o = kde_pkg::event_t'(k);
            done        = 1'b1;
          end else begin
            count_d[k] = inc;
          end
        end else begin
          flag_d[k]  = 1'b0;
          count_d[k] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
      for (int k = 0; k < kde_pkg::NUM_KEYS; k++) begin
        count_q[k] <= '0;
      end
    end else if (step_i) begin
      flag_q <= flag_d;
      for (int k = 0; k < kde_pkg::NUM_KEYS; k++) begin
        count_q[k] <= count_d[k];
      end
    end
  end

endmodule

@@ design/key_debounce_event_detector_top.sv @@
// ----------------------------------------------------------------------------
// key_debounce_event_detector_top: debounced key press event detector
// Input register, per-key update and result register; one sample a cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one beat per key sample (raw_keys_i), in_valid_i/in_stall_o.
//   Output channel: one beat per sample (key_event_o), out_valid_o/out_stall_i.
//   key_event_o is the index of a key that just passed the press minimum, or
//   the no-event code (number of keys) when nothing fired.
//   Config channel: cfg_valid_i/cfg_ready_o writes min_press_count_i; ready is
//   always high. Write it only while no sample is in flight.
//   Path: a sample accepted into the input register moves through the counter
//   update into the result register once that is free. Throughput: one sample
//   per cycle while out_stall_i is low, with a combinational counter update.
//   Stall: while out_stall_i holds a result, one more sample is taken into the
//   input register, then in_stall_o rises until the result moves on.
//   Reset: counters and flags clear, min_press_count returns to 7, both
//   pipeline registers empty.
// ----------------------------------------------------------------------------
module key_debounce_event_detector_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kde_pkg::RAW_W-1:0]   raw_keys_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output kde_pkg::event_t             key_event_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  kde_pkg::count_t             min_press_count_i
);

  logic                       in_valid_q;
  logic [kde_pkg::RAW_W-1:0]  raw_q;
  logic                       out_valid_q;
  kde_pkg::event_t            event_q;
  kde_pkg::event_t            event_d;
  kde_pkg::count_t            min_press_q;
  logic                       step;

  // sample moves on when the result register is free or being emptied
  assign step        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !step;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign key_event_o = event_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_press_q <= kde_pkg::MIN_PRESS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_press_q <= min_press_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      raw_q <= raw_keys_i;
    end
  end

  kde_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .raw_keys_i        (raw_q),
    .min_press_count_i (min_press_q),
    .key_event_o       (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      event_q <= event_d;
    end
  end

endmodule

@@ design/kde_checker.sv @@
// ----------------------------------------------------------------------------
// kde_checker: port-level checks for the key debounce event detector
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module kde_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [kde_pkg::RAW_W-1:0]   raw_keys_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input kde_pkg::event_t             key_event_o
);

  // result beat carries a key index or the no-event code
  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_event_o <= kde_pkg::KEY_NONE)
    else $error("key_event_o out of range");

  // input side only backs up when a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("in_stall_o without a stalled result");

  // a beat accepted while the output is drained reaches the output in time
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted beat lost");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_event_o))
    else $error("stalled result changed");

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(raw_keys_i))
    else $error("stalled input beat changed");

endmodule

bind key_debounce_event_detector_top kde_checker u_kde_checker (.*);

@@ bench/key_debounce_event_detector_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_event_detector_checker: press event scoreboard
// Watches the sample, result and config channels, keeps its own hold counters
// and reported flags per key, and compares every result beat with the
// oldest predicted key event.
// ----------------------------------------------------------------------------
module key_debounce_event_detector_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [kde_pkg::RAW_W-1:0]     raw_keys_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  kde_pkg::event_t               key_event_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  kde_pkg::count_t               min_press_count_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  kde_pkg::count_t              hold_cnt [kde_pkg::NUM_KEYS];
  logic [kde_pkg::NUM_KEYS-1:0] reported;
  kde_pkg::count_t              press_min;
  kde_pkg::event_t              press_q [$];

  // scan keys from index 0, the first key that fires ends the scan
  function automatic kde_pkg::event_t next_press(input logic [kde_pkg::RAW_W-1:0] raw);
    kde_pkg::event_t result;
    logic            held;
    bit              done;
    int              k;
    result = kde_pkg::KEY_NONE;
    done   = 1'b0;
    for (k = 0; k < kde_pkg::NUM_KEYS && !done; k++) begin
      held = (k < kde_pkg::RAW_W) ? raw[k] : 1'b0;
      if (held) begin
        if (hold_cnt[k] != kde_pkg::COUNT_MAX) begin
          hold_cnt[k] = hold_cnt[k] + kde_pkg::count_t'(1);
        end
        if (hold_cnt[k] >= press_min && !reported[k]) begin
          reported[k] = 1'b1;
          hold_cnt[k] = '0;
          result      = kde_pkg::event_t'(k);
          done        = 1'b1;
        end
      end else begin
        reported[k] = 1'b0;
        hold_cnt[k] = '0;
      end
    end
    return result;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kde_pkg::event_t want;
    if (!rst_ni) begin
      for (int k = 0; k < kde_pkg::NUM_KEYS; k++) hold_cnt[k] = '0;
      reported     = '0;
      press_min    = kde_pkg::MIN_PRESS_RESET;
      press_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) press_min = min_press_count_i;
      if (out_valid_i && !out_stall_i) begin
        if (press_q.size() == 0) begin
          $display("%0t: key event with none expected, got %0d", $time, key_event_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = press_q.pop_front();
          if (key_event_i !== want) begin
            $display("%0t: key event mismatch, expected %0d, got %0d",
                     $time, want, key_event_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) press_q.push_back(next_press(raw_keys_i));
      pending_o = press_q.size();
    end
  end

endmodule

@@ bench/key_debounce_event_detector_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_event_detector_top_test: key debounce detector testbench
// Drives key samples in held runs, glitchy runs and noise under several press
// minimums and idle patterns; the checker predicts and compares each event.
// ----------------------------------------------------------------------------
module key_debounce_event_detector_top_test;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [kde_pkg::RAW_W-1:0] raw_keys_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  kde_pkg::event_t           key_event_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  kde_pkg::count_t           min_press_count_i;

  int unsigned fail_count;
  int unsigned pending;
  int          send_idle_pct;
  int          stall_pct;
  int          press_min_now;
  int          quiet_cycles;

  key_debounce_event_detector_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_keys_i        (raw_keys_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .key_event_o       (key_event_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .min_press_count_i (min_press_count_i)
  );

  key_debounce_event_detector_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .raw_keys_i        (raw_keys_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .key_event_i       (key_event_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .min_press_count_i (min_press_count_i),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // counts cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [kde_pkg::RAW_W-1:0] raw);
    logic stalled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_keys_i <= raw;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_press_min(input kde_pkg::count_t value);
    logic rdy;
    drain_results();
    cfg_valid_i       <= 1'b1;
    min_press_count_i <= value;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i   <= 1'b0;
    press_min_now = int'(value);
  endtask

  // runs of one key pattern, some with glitches, some pure noise, a few long
  // enough to saturate the hold counters
  task automatic run_key_traffic(input int n_items);
    int                        sent;
    int                        run_len;
    int                        k;
    bit                        noisy;
    bit                        glitchy;
    bit                        long_hold;
    logic [kde_pkg::RAW_W-1:0] run_keys;
    logic [kde_pkg::RAW_W-1:0] raw;
    sent = 0;
    while (sent < n_items) begin
      run_keys  = kde_pkg::raw_t'($urandom_range(0, 15));
      long_hold = ($urandom_range(0, 99) < 6);
      noisy     = !long_hold && ($urandom_range(0, 99) < 15);
      glitchy   = !long_hold && !noisy && ($urandom_range(0, 99) < 30);
      if (long_hold) run_len = $urandom_range(256, 300);
      else run_len = $urandom_range(1, press_min_now * 2 + 4);
      for (k = 0; k < run_len && sent < n_items; k++) begin
        if (noisy) begin
          raw = kde_pkg::raw_t'($urandom_range(0, 15));
        end else if (glitchy && $urandom_range(0, 99) < 10) begin
          raw = run_keys ^ kde_pkg::raw_t'(1 << $urandom_range(0, kde_pkg::RAW_W - 1));
        end else begin
          raw = run_keys;
        end
        send_sample(raw);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    raw_keys_i        = '0;
    cfg_valid_i       = 1'b0;
    min_press_count_i = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    press_min_now     = 7;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset press minimum: all keys held fire in index order, then one key alone
    send_sample('0);
    repeat (12) send_sample(4'hF);
    send_sample('0);
    repeat (8) send_sample(4'h8);
    send_sample('0);
    send_sample(4'h6);
    run_key_traffic(150);

    write_press_min(kde_pkg::count_t'(1));
    run_key_traffic(300);

    // zero minimum fires on the first held sample
    write_press_min(kde_pkg::count_t'(0));
    send_idle_pct = 58;
    run_key_traffic(250);

    write_press_min(kde_pkg::COUNT_MAX);
    send_idle_pct = 0;
    stall_pct     = 58;
    run_key_traffic(350);

    write_press_min(kde_pkg::count_t'(3));
    send_idle_pct = 16;
    stall_pct     = 16;
    run_key_traffic(300);

    write_press_min(kde_pkg::count_t'($urandom_range(2, 12)));
    send_idle_pct = 0;
    stall_pct     = 0;
    run_key_traffic(150);
    send_idle_pct = 58;
    stall_pct     = 58;
    run_key_traffic(150);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ key_debounce_event_detector_top.f @@
design/kde_pkg.sv
design/kde_core.sv
design/key_debounce_event_detector_top.sv
design/kde_checker.sv
bench/key_debounce_event_detector_checker.sv
bench/key_debounce_event_detector_top_test.sv
